@@ src/tmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg
// Shared constants, codes and types of the tile mask matcher.
// ----------------------------------------------------------------------------
package tmm_pkg;

  localparam int MAX_TILES_DEF = 64;
  localparam int MAX_SIDE_DEF  = 16;

  localparam int CFG_DATA_W = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [7:0] WHITE_LEVEL    = 8'd250;
  localparam logic [4:0] TILE_SIDE_RST  = 5'd8;
  localparam logic [6:0] TILE_COUNT_RST = 7'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TILE_SIDE  = 1'b0,
    REG_TILE_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_FIND
  } state_t;

  typedef struct packed {
    logic fire;
    logic size_ok;
  } find_req_t;

endpackage

@@ src/tmm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tmm_find.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_find
// Registers the hit vector of a finished query and encodes the lowest hit.
// ----------------------------------------------------------------------------
module tmm_find #(
  parameter int MAX_TILES = tmm_pkg::MAX_TILES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tmm_pkg::find_req_t    req,
  input  logic [MAX_TILES-1:0]  hits,
  output logic                  done,
  output logic                  found,
  output logic [5:0]            match_index
);

  logic                 pend;
  logic                 size_ok;
  logic [MAX_TILES-1:0] hits_q;
  logic                 found_next;
  logic [5:0]           match_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= req.fire;
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire) begin
      hits_q  <= hits;
      size_ok <= req.size_ok;
    end
    if (pend) begin
      found       <= found_next;
      match_index <= match_index_next;
    end
  end

  always_comb begin
    found_next       = size_ok && (|hits_q);
    match_index_next = 6'd0;
    for (int t = MAX_TILES - 1; t >= 0; t--) begin
      if (hits_q[t]) begin
        match_index_next = 6'(t);
      end
    end
    if (!found_next) begin
      match_index_next = 6'd0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pend))
    else $error("result strobe without a pending search");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (7'(match_index) < 7'(MAX_TILES)))
    else $error("match index beyond the tile table");

endmodule

@@ src/tile_mask_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_mask_matcher
// Stores white masks of square tiles and finds the first tile that matches
// a streamed candidate.
//
// Channel    Direction  Handshake                 Beat
// input      in         start high, busy low      one load or query pixel
// result     out        done strobe, one cycle    found, match_index
// config     in         cfg_we high               cfg_index, cfg_data
//
// A load or query pixel is handled as a mask word read followed by its
// modification. The last pixel of a query also passes the find state, and
// its result strobes in the cycle in which busy drops, so the next beat may
// be taken at the edge that ends the strobe.
// Reset clears state, config, mismatch and per-word valid flags at once, so
// no clearing pass is needed. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module tile_mask_matcher #(
  parameter int MAX_TILES = tmm_pkg::MAX_TILES_DEF,
  parameter int MAX_SIDE  = tmm_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [5:0]                       tile_slot,
  input  logic [5:0]                       pixel_x,
  input  logic [5:0]                       pixel_y,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  input  logic [6:0]                       query_width,
  input  logic [6:0]                       query_height,
  input  logic                             last_pixel,
  output logic                             done,
  output logic                             found,
  output logic [5:0]                       match_index,
  input  logic                             cfg_we,
  input  logic [tmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  tmm_pkg::state_t      state;
  tmm_pkg::state_t      state_next;
  logic                 accept;
  logic                 proc;

  logic [4:0]           tile_side;
  logic [6:0]           tile_count;

  logic [12:0]          pos_full;
  logic [AW-1:0]        raddr;
  logic [STORE_DEPTH-1:0] word_valid;

  logic                 item_query;
  logic [5:0]           item_slot;
  logic [5:0]           item_px;
  logic [5:0]           item_py;
  logic                 item_white;
  logic [6:0]           item_qw;
  logic [6:0]           item_qh;
  logic                 item_last;
  logic                 item_in_store;
  logic                 item_valid;
  logic [AW-1:0]        item_addr;

  logic [MAX_TILES-1:0] rdata;
  logic [MAX_TILES-1:0] old_word;
  logic [MAX_TILES-1:0] new_word;
  logic                 ram_we;
  logic                 compare;
  logic [MAX_TILES-1:0] contrib;
  logic [MAX_TILES-1:0] mismatch;
  logic [MAX_TILES-1:0] mismatch_next;
  logic [MAX_TILES-1:0] active;
  logic [MAX_TILES-1:0] hits;
  logic                 side_ok;
  tmm_pkg::find_req_t   find_req;

  assign accept   = start && !busy;
  assign pos_full = 13'(pixel_y) * 13'(MAX_SIDE) + 13'(pixel_x);
  assign raddr    = pos_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tmm_pkg::ST_PROC;
        end
      end
      tmm_pkg::ST_PROC: begin
        state_next = (item_query && item_last) ? tmm_pkg::ST_FIND : tmm_pkg::ST_IDLE;
      end
      tmm_pkg::ST_FIND: begin
        state_next = tmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = tmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b1;
    proc = 1'b0;
    unique case (state)
      tmm_pkg::ST_IDLE: busy = 1'b0;
      tmm_pkg::ST_PROC: proc = 1'b1;
      tmm_pkg::ST_FIND: busy = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_side  <= tmm_pkg::TILE_SIDE_RST;
      tile_count <= tmm_pkg::TILE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (tmm_pkg::cfg_reg_t'(cfg_index))
        tmm_pkg::REG_TILE_SIDE:  tile_side  <= cfg_data[4:0];
        tmm_pkg::REG_TILE_COUNT: tile_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_query    <= (action == tmm_pkg::ACT_QUERY);
      item_slot     <= tile_slot;
      item_px       <= pixel_x;
      item_py       <= pixel_y;
      item_white    <= (red > tmm_pkg::WHITE_LEVEL) && (green > tmm_pkg::WHITE_LEVEL)
                       && (blue > tmm_pkg::WHITE_LEVEL);
      item_qw       <= query_width;
      item_qh       <= query_height;
      item_last     <= last_pixel;
      item_in_store <= (7'(pixel_x) < 7'(MAX_SIDE)) && (7'(pixel_y) < 7'(MAX_SIDE));
      item_valid    <= word_valid[raddr];
      item_addr     <= raddr;
    end
  end

  tmm_ram #(
    .WIDTH(MAX_TILES),
    .DEPTH(STORE_DEPTH)
  ) u_mask_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(item_addr),
    .wdata(new_word),
    .re   (accept),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign old_word = item_valid ? rdata : '0;
  assign ram_we   = proc && !item_query && item_in_store
                    && (7'(item_slot) < 7'(MAX_TILES));

  always_comb begin
    new_word = old_word;
    for (int t = 0; t < MAX_TILES; t++) begin
      if (item_slot == 6'(t)) begin
        new_word[t] = item_white;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (ram_we) begin
      word_valid[item_addr] <= 1'b1;
    end
  end

  assign compare = item_in_store && (7'(item_px) < 7'(tile_side))
                   && (7'(item_py) < 7'(tile_side));
  assign contrib = compare ? (item_white ? ~old_word : old_word) : '0;
  assign mismatch_next = mismatch | contrib;

  always_comb begin
    for (int t = 0; t < MAX_TILES; t++) begin
      active[t] = 7'(t) < tile_count;
    end
  end

  assign hits    = ~mismatch_next & active;
  assign side_ok = (tile_side != 5'd0) && (7'(tile_side) <= 7'(MAX_SIDE));

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch <= '0;
    end else if (proc && item_query) begin
      mismatch <= item_last ? '0 : mismatch_next;
    end
  end

  assign find_req.fire    = proc && item_query && item_last;
  assign find_req.size_ok = side_ok && (item_qw == 7'(tile_side)) && (item_qh == 7'(tile_side));

  tmm_find #(
    .MAX_TILES(MAX_TILES)
  ) u_find (
    .clk        (clk),
    .rst        (rst),
    .req        (find_req),
    .hits       (hits),
    .done       (done),
    .found      (found),
    .match_index(match_index)
  );

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == tmm_pkg::ST_FIND))
    else $error("result strobe without a finished query");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == tmm_pkg::ST_PROC))
    else $error("accepted beat not processed");

  assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (match_index == 6'd0))
    else $error("index not zero on a miss");

  assert property (@(posedge clk) disable iff (rst)
    find_req.fire |=> (mismatch == '0))
    else $error("mismatch flags not cleared after a query");

endmodule
